[rtl/pfx_pkg.sv]
// ----------------------------------------------------------------------------
// pfx_pkg
// Types and constants shared by the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DepthW = 6;

  // ASCII codes the evaluator acts on
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;
  localparam logic [2:0] ST_HALTED    = 3'd5;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } pfx_in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [ValueW-1:0] pushed_value;
    logic [DepthW-1:0]        stack_depth;
    logic                     final_valid;
    logic signed [ValueW-1:0] final_value;
  } pfx_out_t;

endpackage

`default_nettype wire

[rtl/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Stack evaluator for postfix expressions, one ASCII character per word.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. The operand stack
// lives in a RAM with a registered read, so every pop waits on a RAM read.
// From acceptance to the result register: a digit or a word ignored while
// halted passes EXEC and FIN, an operator + - * or a divide by zero passes
// EXEC, POP1, POP2, OP, PUSH and FIN, an invalid character passes EXEC,
// POP1, POP2, OP and FIN, a divide adds DIV and DIVF after OP (a restoring
// divider retires one quotient bit per cycle, then a sign fix step), and a
// last word adds the final pop FRD when the stack holds an entry. The next
// word is accepted on the cycle after RESP loads the result into the output
// register, even while the downstream side still stalls it.
`default_nettype none

module postfix_expression_evaluator
  import pfx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pfx_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pfx_out_t      out_word
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_POP1 = 4'd2;
  localparam logic [3:0] S_POP2 = 4'd3;
  localparam logic [3:0] S_OP   = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DIVF = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_FRD  = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              halted_r, halted_nxt;
  logic [7:0]        sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [31:0]       pushed_r, pushed_nxt;
  logic              fvalid_r, fvalid_nxt;
  logic [31:0]       fvalue_r, fvalue_nxt;
  logic [31:0]       right_r, right_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [31:0]       res_r, res_nxt;
  logic              under_r, under_nxt;
  logic              dz_r, dz_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       quo_r, quo_nxt;
  logic [31:0]       dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  pfx_out_t          out_word_r, out_word_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [CW+5:0]     cnt_ext;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_diff;
  logic [7:0]        digit;
  logic              accept;

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign cnt_ext  = {6'd0, cnt_r};
  assign digit    = sym_r - CH_ZERO;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign ram_raddr = (state_r == S_POP1) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
  assign ram_waddr = cnt_r[AW-1:0];

  pfx_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    halted_nxt    = halted_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    pushed_nxt    = pushed_r;
    fvalid_nxt    = fvalid_r;
    fvalue_nxt    = fvalue_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    res_nxt       = res_r;
    under_nxt     = under_r;
    dz_nxt        = dz_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_wdata     = res_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sym_nxt   = in_word.symbol;
          last_nxt  = in_word.last_symbol;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        pushed_nxt = '0;
        fvalid_nxt = 1'b0;
        fvalue_nxt = '0;
        under_nxt  = 1'b0;
        dz_nxt     = 1'b0;
        if (halted_r) begin
          status_nxt = ST_HALTED;
          state_nxt  = S_FIN;
        end else if (sym_r >= CH_ZERO && sym_r <= CH_NINE) begin
          if (cnt_r < CW'(STACK_DEPTH)) begin
            ram_we     = 1'b1;
            ram_wdata  = {24'd0, digit};
            pushed_nxt = {24'd0, digit};
            cnt_nxt    = cnt_r + CW'(1);
          end else begin
            status_nxt = ST_OVERFLOW;
          end
          state_nxt = S_FIN;
        end else begin
          // read of the top entry is in flight
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        right_nxt = (cnt_r >= CW'(1)) ? ram_rdata : '1;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        left_nxt  = (cnt_r >= CW'(2)) ? ram_rdata : '1;
        under_nxt = (cnt_r < CW'(2));
        cnt_nxt   = (cnt_r >= CW'(2)) ? cnt_m2 : '0;
        state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = S_PUSH;
        case (sym_r)
          CH_PLUS:  res_nxt = left_r + right_r;
          CH_MINUS: res_nxt = left_r - right_r;
          CH_STAR:  res_nxt = left_r * right_r;
          CH_SLASH: begin
            if (right_r == '0) begin
              dz_nxt  = 1'b1;
              res_nxt = '0;
            end else begin
              quo_nxt   = left_r[31] ? (32'd0 - left_r) : left_r;
              dvs_nxt   = right_r[31] ? (32'd0 - right_r) : right_r;
              neg_nxt   = left_r[31] ^ right_r[31];
              rem_nxt   = '0;
              dcnt_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
          default: begin
            status_nxt = ST_INVALID;
            halted_nxt = 1'b1;
            state_nxt  = S_FIN;
          end
        endcase
      end
      S_DIV: begin
        // one restoring step per cycle, quotient bits shift into quo_r
        if (!rem_diff[32]) begin
          rem_nxt = rem_diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        res_nxt   = neg_r ? (32'd0 - quo_r) : quo_r;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // at most STACK_DEPTH-2 entries remain after two pops, so it fits
        ram_we     = 1'b1;
        ram_wdata  = res_r;
        pushed_nxt = res_r;
        cnt_nxt    = cnt_r + CW'(1);
        if (under_r) begin
          status_nxt = ST_UNDERFLOW;
        end else if (dz_r) begin
          status_nxt = ST_DIVZERO;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_RESP;
        if (last_r && !halted_r) begin
          if (cnt_r != '0) begin
            state_nxt = S_FRD;
          end else begin
            fvalid_nxt = 1'b1;
            fvalue_nxt = '1;
            if (status_r == ST_OK) begin
              status_nxt = ST_UNDERFLOW;
            end
          end
        end
        if (last_r && (halted_r || cnt_r == '0)) begin
          cnt_nxt    = '0;
          halted_nxt = 1'b0;
        end
      end
      S_FRD: begin
        fvalid_nxt = 1'b1;
        fvalue_nxt = ram_rdata;
        cnt_nxt    = '0;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = status_r;
          out_word_nxt.pushed_value = pushed_r;
          out_word_nxt.stack_depth  = cnt_ext[5:0];
          out_word_nxt.final_valid  = fvalid_r;
          out_word_nxt.final_value  = fvalue_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    pushed_r   <= pushed_nxt;
    fvalid_r   <= fvalid_nxt;
    fvalue_r   <= fvalue_nxt;
    right_r    <= right_nxt;
    left_r     <= left_nxt;
    res_r      <= res_nxt;
    under_r    <= under_nxt;
    dz_r       <= dz_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    dcnt_r     <= dcnt_nxt;
    out_word_r <= out_word_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_resp_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word raised outside the response step");

  a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.final_valid |-> out_word_r.stack_depth == '0)
    else $error("final result left entries on the stack");

  a_no_halt_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && last_r |-> !halted_r)
    else $error("halt survived the last word");

endmodule

`default_nettype wire

[rtl/pfx_ram.sv]
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[test/tb_postfix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking bench for the postfix stack evaluator: a stack predictor
// built into a small scoreboard class forecasts every result word, and both
// handshake sides idle and stall at random around directed and random words.
// ----------------------------------------------------------------------------

module tb_postfix_expression_evaluator
  import pfx_pkg::*;
();

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [7:0]  CH_QUERY     = 8'h3F;
  localparam logic [7:0]  CH_NUL       = 8'h00;
  localparam logic [7:0]  CH_ALL_ONES  = 8'hFF;

  typedef enum int unsigned {
    K_EXPRESSION,
    K_BROKEN,
    K_NOISE,
    K_FILL,
    K_MIN_DIVIDE
  } seq_kind_t;

  // Stack predictor plus the queue of result words still due.
  class postfix_scoreboard;
    logic [31:0] stack_mem [STACK_DEPTH];
    int unsigned depth;
    bit          halted;
    pfx_out_t    due_words [$];
    int unsigned fails;

    function new();
      depth  = 0;
      halted = 1'b0;
      fails  = 0;
    endfunction

    function int unsigned due_count();
      return due_words.size();
    endfunction

    function logic [31:0] pop_operand(inout bit under);
      if (depth == 0) begin
        under = 1'b1;
        return '1;
      end
      depth--;
      return stack_mem[depth];
    endfunction

    function bit push_operand(logic [31:0] v);
      if (depth >= STACK_DEPTH) return 1'b0;
      stack_mem[depth] = v;
      depth++;
      return 1'b1;
    endfunction

    // Signed divide, truncating toward zero, wrapping on the most negative
    // value over minus one.
    function logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? (32'd0 - a) : a;
      mb = b[31] ? (32'd0 - b) : b;
      q  = ma / mb;
      return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    function void note_symbol(pfx_in_t w);
      pfx_out_t    e;
      logic [31:0] rhs;
      logic [31:0] lhs;
      logic [31:0] res;
      bit          under;
      bit          dz;
      bit          known_op;
      e = '0;
      e.status = ST_OK;
      if (halted) begin
        e.status = ST_HALTED;
      end else if (w.symbol >= CH_ZERO && w.symbol <= CH_NINE) begin
        res = {24'd0, w.symbol - CH_ZERO};
        if (push_operand(res)) e.pushed_value = res;
        else e.status = ST_OVERFLOW;
      end else begin
        under    = 1'b0;
        dz       = 1'b0;
        known_op = 1'b1;
        res      = '0;
        rhs      = pop_operand(under);
        lhs      = pop_operand(under);
        case (w.symbol)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          CH_SLASH: begin
            if (rhs == 32'd0) dz = 1'b1;
            else res = trunc_quotient(lhs, rhs);
          end
          default:  known_op = 1'b0;
        endcase
        if (!known_op) begin
          e.status = ST_INVALID;
          halted   = 1'b1;
        end else begin
          if (under) e.status = ST_UNDERFLOW;
          else if (dz) e.status = ST_DIVZERO;
          if (push_operand(res)) e.pushed_value = res;
          else if (e.status == ST_OK) e.status = ST_OVERFLOW;
        end
      end
      if (w.last_symbol) begin
        if (!halted) begin
          under = 1'b0;
          e.final_value = pop_operand(under);
          e.final_valid = 1'b1;
          if (under && e.status == ST_OK) e.status = ST_UNDERFLOW;
        end
        depth  = 0;
        halted = 1'b0;
      end
      e.stack_depth = 6'(depth);
      due_words.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (fails < MAX_PRINTS)
        $display("mismatch %s: got 0x%08h, want 0x%08h", what, got, want);
      fails++;
    endtask

    task check_word(pfx_out_t got);
      pfx_out_t want;
      if (due_words.size() == 0) begin
        report("result word with nothing due", 32'(got.status), 32'd0);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.pushed_value !== want.pushed_value)
        report("pushed_value", got.pushed_value, want.pushed_value);
      if (got.stack_depth !== want.stack_depth)
        report("stack_depth", 32'(got.stack_depth), 32'(want.stack_depth));
      if (got.final_valid !== want.final_valid)
        report("final_valid", 32'(got.final_valid), 32'(want.final_valid));
      if (got.final_value !== want.final_value)
        report("final_value", got.final_value, want.final_value);
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pfx_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pfx_out_t out_word;

  postfix_scoreboard sb = new();
  bit                steady = 1'b0;
  int unsigned       items_sent = 0;
  logic [7:0]        seq_syms [$];

  postfix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check accepted words, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
    out_stall <= !steady && ($urandom_range(99) < 23);
  end

  task automatic send_word(input logic [7:0] sym, input bit last);
    pfx_in_t     w;
    int unsigned gap;
    w.symbol      = sym;
    w.last_symbol = last;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 23) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_symbol(w);
    items_sent++;
  endtask

  // Send the built symbols; the final one always closes the expression.
  task automatic send_symbols(input bit random_last);
    foreach (seq_syms[i])
      send_word(seq_syms[i], (i == seq_syms.size() - 1) ||
                             (random_last && $urandom_range(3) == 0));
  endtask

  // Hold off the sender until every due word is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Well-formed postfix: never pop below two, end with one operand left.
  task automatic build_expression(input int unsigned digits);
    int unsigned to_push;
    int unsigned level;
    to_push = digits;
    level   = 0;
    seq_syms = {};
    while (to_push > 0 || level > 1) begin
      if (level >= 2 && (to_push == 0 || $urandom_range(1) == 1)) begin
        seq_syms.push_back(pick_operator());
        level--;
      end else begin
        seq_syms.push_back(pick_digit());
        level++;
        to_push--;
      end
    end
  endtask

  // 2 * 8^10 wraps to the most negative value, then divide it.
  task automatic build_min_divide();
    seq_syms = {};
    seq_syms.push_back(CH_ZERO + 8'd2);
    repeat (10) seq_syms.push_back(CH_ZERO + 8'd8);
    repeat (10) seq_syms.push_back(CH_STAR);
    if ($urandom_range(2) != 0) begin
      seq_syms.push_back(CH_ZERO);
      seq_syms.push_back(CH_ZERO + 8'd1);
      seq_syms.push_back(CH_MINUS);
    end else begin
      seq_syms.push_back(pick_digit());
    end
    seq_syms.push_back(CH_SLASH);
  endtask

  initial begin
    int unsigned random_base;
    int unsigned round;
    int unsigned guard;
    seq_kind_t   kind;
    int unsigned pick;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: extremes, every operator, divide by zero, underflow, invalid and halted words.
    send_word(CH_ZERO, 1'b1);
    send_word(CH_NINE, 1'b1);
    send_word(CH_ZERO + 8'd7, 1'b0);
    send_word(CH_ZERO + 8'd3, 1'b0);
    send_word(CH_PLUS, 1'b0);
    send_word(CH_NINE, 1'b0);
    send_word(CH_MINUS, 1'b0);
    send_word(CH_ZERO + 8'd4, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_ZERO + 8'd3, 1'b0);
    send_word(CH_SLASH, 1'b1);
    send_word(CH_ZERO + 8'd5, 1'b0);
    send_word(CH_ZERO, 1'b0);
    send_word(CH_SLASH, 1'b1);
    send_word(CH_PLUS, 1'b1);
    send_word(CH_ZERO, 1'b0);
    send_word(CH_SLASH, 1'b1);
    send_word(CH_ZERO + 8'd6, 1'b0);
    send_word(CH_QUERY, 1'b0);
    send_word(CH_ZERO + 8'd8, 1'b0);
    send_word(CH_ZERO + 8'd1, 1'b1);
    send_word(CH_ZERO + 8'd2, 1'b0);
    send_word(CH_NUL, 1'b1);
    send_word(CH_ALL_ONES, 1'b1);
    wait_for_results();

    // Random part: mostly well-formed expressions; a full stack and the
    // most-negative divide come first so they always run.
    random_base = items_sent;
    round = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      steady = (items_sent - random_base >= 400) && (items_sent - random_base < 550);
      pick = $urandom_range(99);
      if (round == 0) kind = K_FILL;
      else if (round == 1) kind = K_MIN_DIVIDE;
      else if (pick < 70) kind = K_EXPRESSION;
      else if (pick < 80) kind = K_BROKEN;
      else if (pick < 88) kind = K_NOISE;
      else if (pick < 94) kind = K_FILL;
      else kind = K_MIN_DIVIDE;
      case (kind)
        K_EXPRESSION: begin
          build_expression(($urandom_range(9) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 8));
          send_symbols(1'b0);
        end
        K_BROKEN: begin
          build_expression($urandom_range(2, 8));
          seq_syms[$urandom_range(seq_syms.size() - 1)] = 8'($urandom_range(255));
          send_symbols(1'b0);
        end
        K_NOISE: begin
          seq_syms = {};
          repeat ($urandom_range(1, 6)) seq_syms.push_back(8'($urandom_range(255)));
          send_symbols(1'b1);
        end
        K_FILL: begin
          seq_syms = {};
          repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
            seq_syms.push_back(pick_digit());
          seq_syms.push_back(pick_operator());
          send_symbols(1'b0);
        end
        default: begin
          build_min_divide();
          send_symbols(1'b0);
        end
      endcase
      if ($urandom_range(19) == 0) wait_for_results();
      round++;
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    guard = 0;
    while (sb.due_count() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.due_count() != 0)
      sb.report("result words never returned", 32'(sb.due_count()), 32'd0);
    if (sb.fails == 0) $display("tb_postfix_expression_evaluator OK");
    else $display("tb_postfix_expression_evaluator NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_postfix_expression_evaluator NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/postfix_expression_evaluator.sv
test/tb_postfix_expression_evaluator.sv
